/* hw/rtl/pffc_pkg.sv */
// Shared types, constants and helper functions of the PCM frame format converter.
package pffc_pkg;

  // Frame geometry.
  localparam int LANES        = 8;
  localparam int SAMPLE_W     = 16;
  localparam int CNT_W        = 4;
  localparam int GAIN_W       = 16;
  localparam int MAX_CHANNELS = 8;
  localparam int DATA_W       = LANES * SAMPLE_W;

  // Downmix arithmetic: a sum of eight 16-bit samples needs 19 bits.
  localparam int SUM_W       = SAMPLE_W + 3;
  localparam int RECIP_SHIFT = 20;
  localparam int RECIP_W     = 20;
  localparam int DM_PROD_W   = SUM_W + RECIP_W;
  localparam int QD_W        = SUM_W + CNT_W;

  // Gain arithmetic in unsigned Q4.12.
  localparam int GAIN_FRAC    = 12;
  localparam int GAIN_PROD_W  = SAMPLE_W + GAIN_W + 1;
  localparam logic [GAIN_W-1:0] UNITY_GAIN = GAIN_W'(1 << GAIN_FRAC);

  // Configuration register indexes.
  localparam int REG_IDX_W = 3;
  localparam logic [REG_IDX_W-1:0] REG_IN_IS_8BIT   = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_IN_CHANNELS  = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_OUT_CHANNELS = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_OUT_IS_8BIT  = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_GAIN         = 3'd4;

  // Reciprocals floor(2^20 / d) for the downmix divisors.
  localparam logic [RECIP_W-1:0] RECIP_2 = RECIP_W'((1 << RECIP_SHIFT) / 2);
  localparam logic [RECIP_W-1:0] RECIP_3 = RECIP_W'((1 << RECIP_SHIFT) / 3);
  localparam logic [RECIP_W-1:0] RECIP_4 = RECIP_W'((1 << RECIP_SHIFT) / 4);
  localparam logic [RECIP_W-1:0] RECIP_5 = RECIP_W'((1 << RECIP_SHIFT) / 5);
  localparam logic [RECIP_W-1:0] RECIP_6 = RECIP_W'((1 << RECIP_SHIFT) / 6);
  localparam logic [RECIP_W-1:0] RECIP_7 = RECIP_W'((1 << RECIP_SHIFT) / 7);
  localparam logic [RECIP_W-1:0] RECIP_8 = RECIP_W'((1 << RECIP_SHIFT) / 8);

  // Upper byte of every lane; must be clear in 8-bit output mode.
  localparam logic [DATA_W-1:0] OUT_HI_MASK = {LANES{16'hFF00}};

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic [LANES-1:0][SAMPLE_W-1:0] lanes_t;

  // Decoded configuration shared by all pipeline stages.
  typedef struct packed {
    logic              in_is_8bit;
    logic [CNT_W-1:0]  ic;
    logic [CNT_W-1:0]  oc;
    logic              out_is_8bit;
    logic [GAIN_W-1:0] gain;
    logic              downmix;
    logic              mono;
    logic              unity;
  } cfg_t;

  // Channel count as used: zero acts as one, large counts saturate.
  function automatic logic [CNT_W-1:0] eff_count(input logic [CNT_W-1:0] c);
    logic [CNT_W-1:0] r;
    if (c == '0) begin
      r = CNT_W'(1);
    end else if (c > CNT_W'(MAX_CHANNELS)) begin
      r = CNT_W'(MAX_CHANNELS);
    end else begin
      r = c;
    end
    return r;
  endfunction

  // Reciprocal lookup for the downmix divider.
  function automatic logic [RECIP_W-1:0] recip(input logic [CNT_W-1:0] d);
    logic [RECIP_W-1:0] r;
    case (d)
      4'd3:    r = RECIP_3;
      4'd4:    r = RECIP_4;
      4'd5:    r = RECIP_5;
      4'd6:    r = RECIP_6;
      4'd7:    r = RECIP_7;
      4'd8:    r = RECIP_8;
      default: r = RECIP_2;
    endcase
    return r;
  endfunction

endpackage

/* hw/rtl/pffc_front.sv */
// One input lane: 8-bit unsigned samples widen to signed 16-bit, 16-bit samples pass through.
module pffc_front (
  input  logic              clk,
  input  logic              en,
  input  logic              in_is_8bit,
  input  pffc_pkg::sample_t raw,
  output pffc_pkg::sample_t s_r
);

  pffc_pkg::sample_t s_nxt;

  // (byte - 0x80) << 8 is the byte with its top bit flipped, placed high.
  always_comb begin
    if (in_is_8bit) begin
      s_nxt = {~raw[7], raw[6:0], 8'h00};
    end else begin
      s_nxt = raw;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s_r <= s_nxt;
    end
  end

endmodule

/* hw/rtl/pffc_downmix.sv */
// Merging stage: averages the active lanes into lane 0 when a downmix is needed.
// Stage 2 sums, stage 3 multiplies the magnitude by a reciprocal, stage 4
// corrects the quotient and restores the sign.
module pffc_downmix (
  input  logic             clk,
  input  logic             en2,
  input  logic             en3,
  input  logic             en4,
  input  pffc_pkg::cfg_t   cfg,
  input  pffc_pkg::lanes_t lanes_in,
  output pffc_pkg::lanes_t lanes_r
);

  logic signed [pffc_pkg::SUM_W-1:0]     sum_nxt;
  logic signed [pffc_pkg::SUM_W-1:0]     sum2_r;
  pffc_pkg::lanes_t                      lanes2_r;
  logic        [pffc_pkg::SUM_W-1:0]     mag_nxt;
  logic        [pffc_pkg::SUM_W-1:0]     mag3_r;
  logic        [pffc_pkg::DM_PROD_W-1:0] prod3_r;
  logic                                  neg3_r;
  pffc_pkg::lanes_t                      lanes3_r;
  logic        [pffc_pkg::SUM_W-1:0]     q_est;
  logic        [pffc_pkg::SUM_W-1:0]     q_fix;
  logic        [pffc_pkg::QD_W-1:0]      qd;
  logic        [pffc_pkg::QD_W-1:0]      rem;
  logic        [pffc_pkg::SUM_W-1:0]     avg;
  pffc_pkg::lanes_t                      lanes_nxt;

  // Sum of the active input lanes.
  always_comb begin
    sum_nxt = '0;
    for (int i = 0; i < pffc_pkg::LANES; i++) begin
      if (pffc_pkg::CNT_W'(i) < cfg.ic) begin
        sum_nxt = sum_nxt + pffc_pkg::SUM_W'($signed(lanes_in[i]));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en2) begin
      sum2_r   <= sum_nxt;
      lanes2_r <= lanes_in;
    end
  end

  // Magnitude times floor(2^20 / count); the estimate is low by at most one.
  assign mag_nxt = sum2_r[pffc_pkg::SUM_W-1] ? pffc_pkg::SUM_W'(-sum2_r)
                                             : pffc_pkg::SUM_W'(sum2_r);

  always_ff @(posedge clk) begin
    if (en3) begin
      mag3_r   <= mag_nxt;
      neg3_r   <= sum2_r[pffc_pkg::SUM_W-1];
      prod3_r  <= pffc_pkg::DM_PROD_W'(mag_nxt) *
                  pffc_pkg::DM_PROD_W'(pffc_pkg::recip(cfg.ic));
      lanes3_r <= lanes2_r;
    end
  end

  // One correction step, then the sign; the quotient truncates toward zero.
  always_comb begin
    q_est = prod3_r[pffc_pkg::DM_PROD_W-1:pffc_pkg::RECIP_SHIFT];
    qd    = pffc_pkg::QD_W'(q_est) * pffc_pkg::QD_W'(cfg.ic);
    rem   = pffc_pkg::QD_W'(mag3_r) - qd;
    if (rem >= pffc_pkg::QD_W'(cfg.ic)) begin
      q_fix = q_est + pffc_pkg::SUM_W'(1);
    end else begin
      q_fix = q_est;
    end
    avg = neg3_r ? pffc_pkg::SUM_W'(-q_fix) : q_fix;
    lanes_nxt = lanes3_r;
    if (cfg.downmix) begin
      lanes_nxt[0] = avg[pffc_pkg::SAMPLE_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en4) begin
      lanes_r <= lanes_nxt;
    end
  end

endmodule

/* hw/rtl/pffc_gain.sv */
// One gain lane: Q4.12 product registered, then truncation toward zero and clamp, or bypass at unity.
module pffc_gain (
  input  logic                          clk,
  input  logic                          en,
  input  logic [pffc_pkg::GAIN_W-1:0]   gain,
  input  logic                          unity,
  input  pffc_pkg::sample_t             s_in,
  output pffc_pkg::sample_t             g
);

  logic signed [pffc_pkg::GAIN_PROD_W-1:0] prod_r;
  pffc_pkg::sample_t                       s_r;
  logic signed [pffc_pkg::GAIN_PROD_W-1:0] biased;
  logic signed [pffc_pkg::GAIN_PROD_W-1:0] scaled;

  always_ff @(posedge clk) begin
    if (en) begin
      prod_r <= $signed(s_in) * $signed({1'b0, gain});
      s_r    <= s_in;
    end
  end

  // Negative products get a bias so the arithmetic shift rounds toward zero.
  always_comb begin
    if (prod_r < 0) begin
      biased = prod_r + pffc_pkg::GAIN_PROD_W'((1 << pffc_pkg::GAIN_FRAC) - 1);
    end else begin
      biased = prod_r;
    end
    scaled = biased >>> pffc_pkg::GAIN_FRAC;
    if (unity) begin
      g = s_r;
    end else if (scaled > pffc_pkg::GAIN_PROD_W'(32767)) begin
      g = 16'sd32767;
    end else if (scaled < -pffc_pkg::GAIN_PROD_W'(32767)) begin
      g = -16'sd32767;
    end else begin
      g = scaled[pffc_pkg::SAMPLE_W-1:0];
    end
  end

endmodule

/* hw/rtl/pcm_frame_format_converter.sv */
// An accepted frame passes stages 1 to 5, then the output register, to reach out_tvalid.
// Throughput: one frame per cycle unless stalled; eight parallel lanes, six-stage pipeline.
// in_tready drops only when all six stages hold frames and the output is stalled.
// Configuration writes are taken every cycle (cfg_ready is always high).
// Reset (rst_n low, synchronous) empties the pipeline and loads the register
// defaults: 16-bit in and out, one channel each way, unity gain.
module pcm_frame_format_converter (
  input  logic                               clk,
  input  logic                               rst_n,
  // Input frame.
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [pffc_pkg::DATA_W-1:0]        in_tdata,  // sample_0 .. sample_7, 16 bits each
  input  logic                               in_tlast,  // end_of_buffer
  // Converted frame.
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [pffc_pkg::DATA_W-1:0]        out_tdata, // out_0 .. out_7, 16 bits each
  output logic                               out_tlast, // end_out
  // Configuration writes.
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [pffc_pkg::REG_IDX_W-1:0]     cfg_index,
  input  logic [pffc_pkg::GAIN_W-1:0]        cfg_data
);

  localparam int NSTAGE = 5;

  logic                            in_is_8bit_r;
  logic [pffc_pkg::CNT_W-1:0]      in_channels_r;
  logic [pffc_pkg::CNT_W-1:0]      out_channels_r;
  logic                            out_is_8bit_r;
  logic [pffc_pkg::GAIN_W-1:0]     gain_r;
  pffc_pkg::cfg_t                  cfg;

  logic [NSTAGE:1]                 valid_r;
  logic [NSTAGE:1]                 last_r;
  logic [NSTAGE+1:1]               en;
  pffc_pkg::lanes_t                front_lanes;
  pffc_pkg::lanes_t                mix_lanes;
  pffc_pkg::lanes_t                gain_lanes;
  logic [pffc_pkg::DATA_W-1:0]     out_nxt;

  // Register writes; unknown indexes are dropped.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_is_8bit_r   <= 1'b0;
      in_channels_r  <= pffc_pkg::CNT_W'(1);
      out_channels_r <= pffc_pkg::CNT_W'(1);
      out_is_8bit_r  <= 1'b0;
      gain_r         <= pffc_pkg::UNITY_GAIN;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        pffc_pkg::REG_IN_IS_8BIT:   in_is_8bit_r   <= cfg_data[0];
        pffc_pkg::REG_IN_CHANNELS:  in_channels_r  <= cfg_data[pffc_pkg::CNT_W-1:0];
        pffc_pkg::REG_OUT_CHANNELS: out_channels_r <= cfg_data[pffc_pkg::CNT_W-1:0];
        pffc_pkg::REG_OUT_IS_8BIT:  out_is_8bit_r  <= cfg_data[0];
        pffc_pkg::REG_GAIN:         gain_r         <= cfg_data;
        default: ;
      endcase
    end
  end

  // Decoded configuration.
  always_comb begin
    cfg.in_is_8bit  = in_is_8bit_r;
    cfg.ic          = pffc_pkg::eff_count(in_channels_r);
    cfg.oc          = pffc_pkg::eff_count(out_channels_r);
    cfg.out_is_8bit = out_is_8bit_r;
    cfg.gain        = gain_r;
    cfg.downmix     = (cfg.ic != cfg.oc) && (cfg.ic > pffc_pkg::CNT_W'(1));
    cfg.mono        = cfg.downmix || (cfg.ic == pffc_pkg::CNT_W'(1));
    cfg.unity       = (gain_r == pffc_pkg::UNITY_GAIN);
  end

  // A stage advances when it is empty or the stage after it advances.
  always_comb begin
    en[NSTAGE+1] = !out_tvalid || out_tready;
    for (int k = NSTAGE; k >= 1; k--) begin
      en[k] = !valid_r[k] || en[k+1];
    end
  end

  assign in_tready = en[1];

  // Valid and frame-end bits travel with each stage.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r    <= '0;
      out_tvalid <= 1'b0;
    end else begin
      if (en[1]) begin
        valid_r[1] <= in_tvalid;
      end
      for (int k = 2; k <= NSTAGE; k++) begin
        if (en[k]) begin
          valid_r[k] <= valid_r[k-1];
        end
      end
      if (en[NSTAGE+1]) begin
        out_tvalid <= valid_r[NSTAGE];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      last_r[1] <= in_tlast;
    end
    for (int k = 2; k <= NSTAGE; k++) begin
      if (en[k]) begin
        last_r[k] <= last_r[k-1];
      end
    end
    if (en[NSTAGE+1]) begin
      out_tlast <= last_r[NSTAGE];
    end
  end

  // Stage 1: input widening, one lane per channel.
  for (genvar i = 0; i < pffc_pkg::LANES; i++) begin : g_front
    pffc_front u_front (
      .clk        (clk),
      .en         (en[1]),
      .in_is_8bit (cfg.in_is_8bit),
      .raw        (in_tdata[i*pffc_pkg::SAMPLE_W +: pffc_pkg::SAMPLE_W]),
      .s_r        (front_lanes[i])
    );
  end

  // Stages 2 to 4: downmix to mono when needed, else the lanes pass through.
  pffc_downmix u_downmix (
    .clk      (clk),
    .en2      (en[2]),
    .en3      (en[3]),
    .en4      (en[4]),
    .cfg      (cfg),
    .lanes_in (front_lanes),
    .lanes_r  (mix_lanes)
  );

  // Stage 5: gain, one lane per channel.
  for (genvar i = 0; i < pffc_pkg::LANES; i++) begin : g_gain
    pffc_gain u_gain (
      .clk   (clk),
      .en    (en[5]),
      .gain  (cfg.gain),
      .unity (cfg.unity),
      .s_in  (mix_lanes[i]),
      .g     (gain_lanes[i])
    );
  end

  // Output stage: mono copy, unused lanes cleared, optional 8-bit format.
  always_comb begin
    logic [pffc_pkg::SAMPLE_W-1:0] x;
    out_nxt = '0;
    for (int i = 0; i < pffc_pkg::LANES; i++) begin
      x = cfg.mono ? gain_lanes[0] : gain_lanes[i];
      if (pffc_pkg::CNT_W'(i) < cfg.oc) begin
        if (cfg.out_is_8bit) begin
          out_nxt[i*pffc_pkg::SAMPLE_W +: pffc_pkg::SAMPLE_W] = {8'h00, ~x[15], x[14:8]};
        end else begin
          out_nxt[i*pffc_pkg::SAMPLE_W +: pffc_pkg::SAMPLE_W] = x;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[NSTAGE+1]) begin
      out_tdata <= out_nxt;
    end
  end

  // An accepted frame always lands in the first stage.
  a_accept_lands: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> valid_r[1])
    else $error("accepted frame did not enter the pipeline");

  // The highest lane is cleared whenever fewer than eight outputs are active.
  a_unused_lane_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (cfg.oc != pffc_pkg::CNT_W'(8)) |->
      out_tdata[pffc_pkg::DATA_W-1 -: pffc_pkg::SAMPLE_W] == '0)
    else $error("unused output lane is not zero");

  // 8-bit output leaves every upper byte clear.
  a_byte_format: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && cfg.out_is_8bit |-> (out_tdata & pffc_pkg::OUT_HI_MASK) == '0)
    else $error("8-bit output has upper bits set");

  // Zero gain mutes lane 0 of 16-bit output.
  a_zero_gain_mute: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (cfg.gain == '0) && !cfg.out_is_8bit |->
      out_tdata[pffc_pkg::SAMPLE_W-1:0] == '0)
    else $error("zero gain did not mute lane 0");

endmodule
